// File: rtl/lert_pkg.sv
package lert_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 32;
    localparam int WORD_WIDTH  = 16;
    localparam int PAGE_W      = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Stream field widths.
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 6;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 32;

    // Operation kinds.
    localparam logic [KIND_W-1:0] K_READ   = 3'd0;
    localparam logic [KIND_W-1:0] K_LEARN  = 3'd1;
    localparam logic [KIND_W-1:0] K_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] K_SET    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd7;

    // One stored rule, without its page.
    typedef struct packed {
        logic [WORD_WIDTH-1:0] feedback;
        logic [WORD_WIDTH-1:0] prev_input;
        logic [WORD_WIDTH-1:0] in_rise;
        logic [WORD_WIDTH-1:0] in_fall;
        logic [WORD_WIDTH-1:0] out_rise;
        logic [WORD_WIDTH-1:0] out_fall;
    } t_rule;

    // Write-side commands to the rule store.
    typedef struct packed {
        logic              wr_en;
        logic              rm_en;
        logic              clr_en;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] page;
    } t_store_ctl;

    function automatic logic [WORD_WIDTH-1:0] rise_of(input logic [WORD_WIDTH-1:0] o,
                                                       input logic [WORD_WIDTH-1:0] n);
        return (o ^ n) & n;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] fall_of(input logic [WORD_WIDTH-1:0] o,
                                                       input logic [WORD_WIDTH-1:0] n);
        return (o ^ n) & o;
    endfunction

endpackage

// File: rtl/lert_rule_store.sv
module lert_rule_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [lert_pkg::IDX_W-1:0] i_rd_addr,
    output lert_pkg::t_rule       o_rd_rule,
    output logic [lert_pkg::PAGE_W-1:0] o_rd_page,
    output logic                  o_rd_valid,
    input  lert_pkg::t_store_ctl  i_ctl,
    input  lert_pkg::t_rule       i_wr_rule
);
    import lert_pkg::*;

    t_rule             mem_rule [TABLE_DEPTH];
    logic [PAGE_W-1:0] mem_page [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    // Rule and page memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem_rule[i_ctl.idx] <= i_wr_rule;
            mem_page[i_ctl.idx] <= i_ctl.page;
        end
        if (i_rd_en) begin
            o_rd_rule <= mem_rule[i_rd_addr];
            o_rd_page <= mem_page[i_rd_addr];
        end
    end

    // Valid bits mark used slots; an invalid slot reads back with its valid flag low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_rd_en) begin
                o_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_ctl.clr_en) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_ctl.idx] <= 1'b1;
            end else if (i_ctl.rm_en) begin
                r_valid[i_ctl.idx] <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // Learning only ever fills a free slot.
    a_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !r_valid[i_ctl.idx])
        else $error("rule written over a used slot");
    // Removal only frees a used slot.
    a_rm_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rm_en |-> r_valid[i_ctl.idx])
        else $error("rule removed from a free slot");
    // Clearing empties the whole table.
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr_en |=> (r_valid == '0))
        else $error("table not empty after clear");
`endif

endmodule

// File: rtl/learned_edge_rule_table.sv
// Learned edge rule table: a sequencer that learns rules mapping input-word
// edges (and, by page, the current output and earlier input) to output-word
// edges. Read, learn and remove walk the rule memory one slot per cycle through
// its single read port and stop early when a read, learn or remove finds a
// matching rule; a read or learn with an unchanged input, a read of an empty
// table, a learn to page zero, clear, set output and the unused kinds skip the
// walk. One operation is in work at a time, and the next beat is taken while
// the previous result still waits in the output register.
// Slot occupancy is kept in flip-flops, so the table is usable right after
// reset with no clearing pass.
module learned_edge_rule_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [15:0] pin_value, [31:16] next_output, [39:32] rule_page
    input  logic [lert_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // [2:0] kind
    input  logic [lert_pkg::KIND_W-1:0]   i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] output_value, [18:16] status, [24:19] used_entries, [31:25] zero
    output logic [lert_pkg::OUT_DW-1:0]   o_m_axis_tdata
);
    import lert_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind;
    logic [WORD_WIDTH-1:0] r_pin, r_nxt, r_last, r_out;
    logic [PAGE_W-1:0]     r_page;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      r_rd_addr;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_hit, r_free_found;
    logic [IDX_W-1:0]      r_hit_idx, r_free_idx;
    logic [WORD_WIDTH-1:0] r_hit_out;
    logic                  r_o_valid;
    logic [OUT_DW-1:0]     r_o_data;

    // Input beat fields.
    logic [WORD_WIDTH-1:0] in_pin, in_nxt;
    logic [PAGE_W-1:0]     in_page;
    logic                  s_accept, need_scan, fin_go;

    assign in_pin  = i_s_axis_tdata[WORD_WIDTH-1:0];
    assign in_nxt  = i_s_axis_tdata[16 +: WORD_WIDTH];
    assign in_page = i_s_axis_tdata[32 +: PAGE_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign fin_go          = (r_state == S_FIN) && (!r_o_valid || i_m_axis_tready);

    // Only operations that look up the table walk it.
    always_comb begin
        need_scan = 1'b0;
        unique case (i_s_axis_tuser)
            K_READ:   need_scan = (in_pin != r_last) && (r_used != '0);
            K_LEARN:  need_scan = (in_pin != r_last) && (in_page != '0);
            K_REMOVE: need_scan = 1'b1;
            default:  need_scan = 1'b0;
        endcase
    end

    // Edges of the held operation.
    logic [WORD_WIDTH-1:0] rise, fall;
    logic                  changed;
    assign rise    = rise_of(r_last, r_pin);
    assign fall    = fall_of(r_last, r_pin);
    assign changed = (r_pin != r_last);

    // Rule store.
    t_rule             rd_rule, wr_rule;
    logic [PAGE_W-1:0] rd_page;
    logic              rd_valid, rd_en;
    t_store_ctl        ctl;

    assign rd_en = (r_state == S_SCAN) && (r_rd_addr != CNT_W'(TABLE_DEPTH));

    lert_rule_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_addr[IDX_W-1:0]),
        .o_rd_rule  (rd_rule),
        .o_rd_page  (rd_page),
        .o_rd_valid (rd_valid),
        .i_ctl      (ctl),
        .i_wr_rule  (wr_rule)
    );

    // Match of the slot whose data just came back.
    logic cmp_hit, scan_last;
    always_comb begin
        cmp_hit = rd_valid && (rd_rule.in_rise == rise) && (rd_rule.in_fall == fall);
        if (rd_page >= PAGE_W'(2)) begin
            cmp_hit = cmp_hit && (rd_rule.feedback == r_out);
        end
        if (rd_page >= PAGE_W'(3)) begin
            cmp_hit = cmp_hit && (rd_rule.prev_input == r_last);
        end
        cmp_hit = cmp_hit && r_cmp_vld;
    end
    assign scan_last = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_DEPTH - 1));

    // Learned rule contents.
    always_comb begin
        wr_rule.feedback   = r_out;
        wr_rule.prev_input = r_last;
        wr_rule.in_rise    = rise;
        wr_rule.in_fall    = fall;
        wr_rule.out_rise   = rise_of(r_out, r_nxt);
        wr_rule.out_fall   = fall_of(r_out, r_nxt);
    end

    // Store commands, issued in the commit cycle.
    always_comb begin
        ctl        = '0;
        ctl.idx    = r_hit_idx;
        ctl.page   = r_page;
        if (fin_go) begin
            unique case (r_kind)
                K_LEARN: begin
                    ctl.wr_en = (r_page != '0) && changed && !r_hit && r_free_found;
                    ctl.idx   = r_free_idx;
                end
                K_REMOVE: ctl.rm_en  = r_hit;
                K_CLEAR:  ctl.clr_en = 1'b1;
                default:  ctl = ctl;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_accept) n_state = need_scan ? S_SCAN : S_FIN;
            S_SCAN: if (cmp_hit || scan_last) n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commit: result status and state updates.
    logic [STATUS_W-1:0]   fin_status;
    logic [WORD_WIDTH-1:0] fin_out, fin_last;
    logic [CNT_W-1:0]      fin_used;
    always_comb begin
        fin_status = ST_NONE;
        fin_out    = r_out;
        fin_last   = r_last;
        fin_used   = r_used;
        unique case (r_kind)
            K_READ: begin
                if (!changed) begin
                    fin_status = ST_NO_CHANGE;
                end else if (r_used == '0) begin
                    fin_status = ST_EMPTY;
                    fin_last   = r_pin;
                end else begin
                    fin_status = r_hit ? ST_DONE : ST_NOT_FOUND;
                    fin_out    = r_hit ? r_hit_out : r_out;
                    fin_last   = r_pin;
                end
            end
            K_LEARN: begin
                if ((r_page != '0) && changed) begin
                    if (r_hit) begin
                        fin_status = ST_CONFLICT;
                    end else if (r_free_found) begin
                        fin_status = ST_STORED;
                        fin_used   = r_used + CNT_W'(1);
                    end else begin
                        fin_status = ST_FULL;
                    end
                end
            end
            K_REMOVE: begin
                fin_status = r_hit ? ST_DONE : ST_NOT_FOUND;
                if (r_hit) fin_used = r_used - CNT_W'(1);
            end
            K_CLEAR: begin
                fin_status = (r_used != '0) ? ST_DONE : ST_NONE;
                fin_used   = '0;
                fin_out    = '0;
            end
            K_SET:   fin_out = r_nxt;
            default: fin_status = ST_NONE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_out     <= '0;
            r_used    <= '0;
            r_o_valid <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (fin_go) begin
                r_last    <= fin_last;
                r_out     <= fin_out;
                r_used    <= fin_used;
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Operation and scan registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind       <= i_s_axis_tuser;
            r_pin        <= in_pin;
            r_nxt        <= in_nxt;
            r_page       <= in_page;
            r_rd_addr    <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (rd_en) r_rd_addr <= r_rd_addr + CNT_W'(1);
            if (cmp_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_out <= (rd_rule.feedback | rd_rule.out_rise) & ~rd_rule.out_fall;
            end
            if (r_cmp_vld && !rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
        r_cmp_idx <= r_rd_addr[IDX_W-1:0];
        if (fin_go) begin
            r_o_data <= {(OUT_DW - WORD_WIDTH - STATUS_W - USED_W)'(0),
                         USED_W'(fin_used), fin_status, fin_out};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

`ifndef ASSERT_OFF
    // The used count never passes the table depth.
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("used count above table depth");
    // An accepted beat closes the input until its result is committed.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("second beat taken while an operation is in work");
    // A commit waits while the previous result is still unclaimed.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && r_o_valid && !i_m_axis_tready |=> (r_state == S_FIN))
        else $error("result register overwritten");
    // A scan never runs past the last slot.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_last |=> (r_state != S_SCAN))
        else $error("scan did not end after the last slot");
`endif

endmodule

// File: tb/tb_learned_edge_rule_table.sv
module tb_learned_edge_rule_table;
    import lert_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int N_PHASES     = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;
    localparam int POOL_SIZE    = 6;
    localparam int MAX_SEQ      = 5;

    // Kinds the block accepts but ignores.
    localparam logic [KIND_W-1:0] K_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] K_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] K_RSVD7 = 3'd7;

    // One result beat, packed as on the master side (value in the low bits).
    typedef struct packed {
        logic [USED_W-1:0]     used;
        logic [STATUS_W-1:0]   status;
        logic [WORD_WIDTH-1:0] value;
    } t_result;

    // One row of the directed stimulus table.
    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [WORD_WIDTH-1:0] pin;
        logic [WORD_WIDTH-1:0] nxt;
        logic [PAGE_W-1:0]     page;
        bit                    known;
        t_result               res;
    } t_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DW-1:0]      s_data  = '0;
    logic [KIND_W-1:0]     s_kind  = K_READ;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DW-1:0]     o_m_axis_tdata;

    // Shadow copy of the sequencer state.
    logic [WORD_WIDTH-1:0] shadow_last;
    logic [WORD_WIDTH-1:0] shadow_out;
    int unsigned           shadow_used;
    logic [PAGE_W-1:0]     shadow_page [TABLE_DEPTH];
    t_rule                 shadow_rule [TABLE_DEPTH];

    t_result               pending_results [$];
    t_row                  directed_rows [$];
    logic [WORD_WIDTH-1:0] word_pool [POOL_SIZE];

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_req      = 1'b0;
    int  quiet_cycles  = 0;
    int  n_fail        = 0;
    int  items_sent    = 0;

    learned_edge_rule_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // First used rule whose edges, and by page output and earlier input, match.
    function automatic int find_rule(input logic [WORD_WIDTH-1:0] rise,
                                     input logic [WORD_WIDTH-1:0] fall);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (shadow_page[i] != 0 && shadow_rule[i].in_rise == rise &&
                shadow_rule[i].in_fall == fall &&
                (shadow_page[i] < 2 || shadow_rule[i].feedback == shadow_out) &&
                (shadow_page[i] < 3 || shadow_rule[i].prev_input == shadow_last))
                return i;
        end
        return -1;
    endfunction

    // Advance the shadow state by one operation and return its result beat.
    function automatic t_result sequencer_step(input logic [KIND_W-1:0]     kind,
                                               input logic [WORD_WIDTH-1:0] pin,
                                               input logic [WORD_WIDTH-1:0] nxt,
                                               input logic [PAGE_W-1:0]     page);
        logic [WORD_WIDTH-1:0] rise;
        logic [WORD_WIDTH-1:0] fall;
        logic [STATUS_W-1:0]   status;
        t_result               res;
        int                    hit;
        int                    slot;

        rise   = (shadow_last ^ pin) & pin;
        fall   = (shadow_last ^ pin) & shadow_last;
        status = ST_NONE;
        case (kind)
            K_READ: begin
                if ((rise | fall) == 0) begin
                    status = ST_NO_CHANGE;
                end else if (shadow_used == 0) begin
                    status      = ST_EMPTY;
                    shadow_last = pin;
                end else begin
                    hit = find_rule(rise, fall);
                    if (hit >= 0) begin
                        status     = ST_DONE;
                        shadow_out = (shadow_rule[hit].feedback | shadow_rule[hit].out_rise)
                                     & ~shadow_rule[hit].out_fall;
                    end else begin
                        status = ST_NOT_FOUND;
                    end
                    shadow_last = pin;
                end
            end
            K_LEARN: begin
                if (page != 0 && (rise | fall) != 0) begin
                    if (find_rule(rise, fall) >= 0) begin
                        status = ST_CONFLICT;
                    end else begin
                        slot = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (slot < 0 && shadow_page[i] == 0)
                                slot = i;
                        end
                        if (slot < 0) begin
                            status = ST_FULL;
                        end else begin
                            shadow_page[slot]            = page;
                            shadow_rule[slot].feedback   = shadow_out;
                            shadow_rule[slot].prev_input = shadow_last;
                            shadow_rule[slot].in_rise    = rise;
                            shadow_rule[slot].in_fall    = fall;
                            shadow_rule[slot].out_rise   = (shadow_out ^ nxt) & nxt;
                            shadow_rule[slot].out_fall   = (shadow_out ^ nxt) & shadow_out;
                            shadow_used++;
                            status = ST_STORED;
                        end
                    end
                end
            end
            K_REMOVE: begin
                hit = find_rule(rise, fall);
                if (hit >= 0) begin
                    shadow_page[hit] = '0;
                    shadow_used--;
                    status = ST_DONE;
                end else begin
                    status = ST_NOT_FOUND;
                end
            end
            K_CLEAR: begin
                if (shadow_used != 0)
                    status = ST_DONE;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    shadow_page[i] = '0;
                shadow_used = 0;
                shadow_out  = '0;
            end
            K_SET: begin
                shadow_out = nxt;
            end
            default: begin
            end
        endcase
        res.value  = shadow_out;
        res.status = status;
        res.used   = USED_W'(shadow_used);
        return res;
    endfunction

    // Offer one beat, with a random gap first, and record its expected result.
    task automatic send_op(input logic [KIND_W-1:0]     kind,
                           input logic [WORD_WIDTH-1:0] pin,
                           input logic [WORD_WIDTH-1:0] nxt,
                           input logic [PAGE_W-1:0]     page);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= {page, nxt, pin};
        s_kind  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(sequencer_step(kind, pin, nxt, page));
        if (kind <= K_SET)
            items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input logic [KIND_W-1:0]     kind,
                           input logic [WORD_WIDTH-1:0] pin,
                           input logic [WORD_WIDTH-1:0] nxt,
                           input logic [PAGE_W-1:0]     page,
                           input bit                    known,
                           input logic [WORD_WIDTH-1:0] value,
                           input logic [STATUS_W-1:0]   status,
                           input logic [USED_W-1:0]     used);
        t_row row;
        row.kind       = kind;
        row.pin        = pin;
        row.nxt        = nxt;
        row.page       = page;
        row.known      = known;
        row.res.value  = value;
        row.res.status = status;
        row.res.used   = used;
        directed_rows.push_back(row);
    endtask

    function automatic logic [WORD_WIDTH-1:0] pick_word();
        if ($urandom_range(99) < 80)
            return word_pool[$urandom_range(POOL_SIZE - 1)];
        return WORD_WIDTH'($urandom());
    endfunction

    // Mostly the three compare levels, now and then a disabled or a high page.
    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 70)
            return PAGE_W'($urandom_range(3, 1));
        if (r < 85)
            return PAGE_W'($urandom_range(15, 4));
        return PAGE_W'($urandom_range(255, 16));
    endfunction

    // One random episode; most teach a word sequence and then replay it.
    task automatic run_episode();
        logic [WORD_WIDTH-1:0] seq [MAX_SEQ];
        logic [WORD_WIDTH-1:0] start_out;
        logic [WORD_WIDTH-1:0] w;
        int                    r;
        int                    n;

        r = $urandom_range(99);
        if ($urandom_range(9) == 0)
            word_pool[$urandom_range(POOL_SIZE - 1)] = WORD_WIDTH'($urandom());
        if (r < 55) begin
            n         = $urandom_range(MAX_SEQ, 2);
            start_out = WORD_WIDTH'($urandom());
            for (int i = 0; i < n; i++)
                seq[i] = pick_word();
            send_op(K_SET, WORD_WIDTH'($urandom()), start_out, PAGE_W'($urandom()));
            send_op(K_READ, seq[0], WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
            for (int i = 1; i < n; i++) begin
                send_op(K_LEARN, seq[i], WORD_WIDTH'($urandom()), pick_page());
                send_op(K_READ, seq[i], WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
            end
            repeat ($urandom_range(2, 1)) begin
                send_op(K_READ, seq[0], WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
                send_op(K_SET, WORD_WIDTH'($urandom()), start_out, PAGE_W'($urandom()));
                for (int i = 1; i < n; i++)
                    send_op(K_READ, seq[i], WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
            end
        end else if (r < 70) begin
            repeat ($urandom_range(4, 1))
                send_op(KIND_W'($urandom_range(7)), pick_word(), WORD_WIDTH'($urandom()),
                        PAGE_W'($urandom()));
        end else if (r < 80) begin
            w = pick_word();
            send_op(K_READ, w, WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
            if ($urandom_range(3) != 0)
                w = pick_word();
            send_op(K_REMOVE, w, WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
            send_op(K_READ, w, WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
        end else if (r < 85) begin
            send_op(K_CLEAR, WORD_WIDTH'($urandom()), WORD_WIDTH'($urandom()),
                    PAGE_W'($urandom()));
        end else if (r < 88) begin
            // Enough learns to run the table full.
            repeat (TABLE_DEPTH + 2)
                send_op(K_LEARN, WORD_WIDTH'($urandom()), WORD_WIDTH'($urandom()),
                        PAGE_W'($urandom_range(255, 1)));
        end else begin
            send_op(K_SET, WORD_WIDTH'($urandom()), WORD_WIDTH'($urandom()),
                    PAGE_W'($urandom()));
            repeat ($urandom_range(4, 1))
                send_op(K_READ, pick_word(), WORD_WIDTH'($urandom()), PAGE_W'($urandom()));
        end
    endtask

    // Compare one result beat with the oldest expectation.
    task automatic check_result(input logic [OUT_DW-1:0] beat);
        t_result want;
        t_result got;
        got = beat[USED_W+STATUS_W+WORD_WIDTH-1:0];
        if (pending_results.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("unexpected result beat %h", beat);
        end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.used !== want.used || beat[OUT_DW-1:USED_W+STATUS_W+WORD_WIDTH] !== '0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("mismatch: value %h/%h status %0d/%0d used %0d/%0d (exp/act)",
                             want.value, got.value, want.status, got.status,
                             want.used, got.used);
            end
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, checking and watchdog.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_ready)
                check_result(o_m_axis_tdata);
            if ((o_m_axis_tvalid && m_ready) || (s_valid && o_s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Stimulus: reset, directed table, then random phases with varied idling.
    initial begin
        int base;
        shadow_last = '0;
        shadow_out  = '0;
        shadow_used = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_page[i] = '0;
            shadow_rule[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            word_pool[i] = WORD_WIDTH'($urandom());

        add_row(K_READ,   16'h0000, 16'h0000, 8'd0,   1'b1, 16'h0000, ST_NO_CHANGE, 6'd0);
        add_row(K_READ,   16'hFFFF, 16'hFFFF, 8'd255, 1'b1, 16'h0000, ST_EMPTY,     6'd0);
        add_row(K_LEARN,  16'h0000, 16'hFFFF, 8'd0,   1'b1, 16'h0000, ST_NONE,      6'd0);
        add_row(K_LEARN,  16'h0000, 16'hFFFF, 8'd1,   1'b1, 16'h0000, ST_STORED,    6'd1);
        add_row(K_LEARN,  16'h0000, 16'h5555, 8'd255, 1'b1, 16'h0000, ST_CONFLICT,  6'd1);
        add_row(K_LEARN,  16'hFFFF, 16'h5555, 8'd1,   1'b1, 16'h0000, ST_NONE,      6'd1);
        add_row(K_READ,   16'h0000, 16'h0000, 8'd0,   1'b1, 16'hFFFF, ST_DONE,      6'd1);
        add_row(K_SET,    16'h0000, 16'h1234, 8'd0,   1'b1, 16'h1234, ST_NONE,      6'd1);
        add_row(K_LEARN,  16'h00FF, 16'h0000, 8'd2,   1'b1, 16'h1234, ST_STORED,    6'd2);
        add_row(K_LEARN,  16'h8000, 16'hABCD, 8'd3,   1'b1, 16'h1234, ST_STORED,    6'd3);
        add_row(K_READ,   16'h00FF, 16'h0000, 8'd0,   1'b1, 16'h0000, ST_DONE,      6'd3);
        add_row(K_READ,   16'h00FF, 16'h0000, 8'd0,   1'b1, 16'h0000, ST_NO_CHANGE, 6'd3);
        add_row(K_REMOVE, 16'h00FF, 16'h0000, 8'd0,   1'b1, 16'h0000, ST_NOT_FOUND, 6'd3);
        add_row(K_READ,   16'h0000, 16'h0000, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_SET,    16'h0000, 16'h1234, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_READ,   16'h8000, 16'h0000, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_RSVD5,  16'hFFFF, 16'hFFFF, 8'd255, 1'b0, '0, ST_NONE, '0);
        add_row(K_RSVD6,  16'h0000, 16'h0000, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_RSVD7,  16'hFFFF, 16'hFFFF, 8'd255, 1'b0, '0, ST_NONE, '0);
        add_row(K_READ,   16'h0000, 16'h0000, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_SET,    16'h0000, 16'h1234, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_REMOVE, 16'h8000, 16'h0000, 8'd0,   1'b0, '0, ST_NONE, '0);
        add_row(K_CLEAR,  16'hFFFF, 16'hFFFF, 8'd255, 1'b1, 16'h0000, ST_DONE,      6'd0);
        add_row(K_CLEAR,  16'h0000, 16'h0000, 8'd0,   1'b1, 16'h0000, ST_NONE,      6'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run back to back; a typed result replaces the prediction.
        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].kind, directed_rows[i].pin, directed_rows[i].nxt,
                    directed_rows[i].page);
            if (directed_rows[i].known)
                pending_results[pending_results.size() - 1] = directed_rows[i].res;
        end
        drain();

        // Random phases; each ends with a pause until all results are back.
        base = items_sent;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 52; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            while (items_sent < base + (ph + 1) * RANDOM_ITEMS / N_PHASES)
                run_episode();
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (n_fail == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
